### rtl/core/phv_pkg.sv
package phv_pkg;

   // Default sizes for the top-level parameters
   localparam int MAX_LEN_DEF     = 1024;
   localparam int ALPHABET_DEF    = 32;
   localparam int SCORE_WIDTH_DEF = 32;

   // Fixed field widths
   localparam int OP_W      = 3;
   localparam int SYM_W     = 5;
   localparam int POS_W     = 10;
   localparam int LEN_W     = 11;
   localparam int VAL_W     = 32;
   localparam int OUT_W     = 32;
   localparam int CSR_IDX_W = 3;
   localparam int END_W     = 2;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_MATCH = 3'd0,
      OP_LOAD_GAP   = 3'd1,
      OP_FIRST_SYM  = 3'd2,
      OP_SECOND_SYM = 3'd3,
      OP_RUN        = 3'd4
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MATCH_TO_MATCH = 3'd0,
      REG_GAP_TO_MATCH   = 3'd1,
      REG_MATCH_TO_GAP   = 3'd2,
      REG_GAP_EXTEND     = 3'd3,
      REG_GAP_SWITCH     = 3'd4,
      REG_FIRST_LEN      = 3'd5,
      REG_SECOND_LEN     = 3'd6
   } reg_type;

   localparam logic [END_W-1:0] END_MATCH  = 2'd0;
   localparam logic [END_W-1:0] END_INSERT = 2'd1;
   localparam logic [END_W-1:0] END_DELETE = 2'd2;

   // Read strobes for the sequence and emission stores
   typedef struct packed {
      logic fs_rd;
      logic row_gap_rd;
      logic ss_rd;
      logic em_rd;
   } store_ctl_type;

   // Row memory access and cell boundary flags
   typedef struct packed {
      logic rd;
      logic calc;
      logic first_row;
      logic first_col;
   } cell_ctl_type;

   // Saturate a value into a w-bit signed range, sign extended to 64 bits
   function automatic logic signed [63:0] phv_sat(input logic signed [64:0] v,
                                                 input int unsigned w);
      logic signed [64:0] hi;
      logic signed [64:0] lo;
      hi = (65'sd1 <<< (w - 1)) - 65'sd1;
      lo = -hi - 65'sd1;
      if (v > hi) return hi[63:0];
      if (v < lo) return lo[63:0];
      return v[63:0];
   endfunction

   // Saturating add where the most negative value absorbs
   function automatic logic signed [63:0] phv_sadd(input logic signed [63:0] a,
                                                  input logic signed [63:0] b,
                                                  input int unsigned w);
      logic signed [64:0] lo;
      lo = -((65'sd1 <<< (w - 1)) - 65'sd1) - 65'sd1;
      if (65'(a) == lo || 65'(b) == lo) return lo[63:0];
      return phv_sat(65'(a) + 65'(b), w);
   endfunction

endpackage

### rtl/core/phv_store.sv
module phv_store #(
   parameter int MAX_LEN     = phv_pkg::MAX_LEN_DEF,
   parameter int ALPHABET    = phv_pkg::ALPHABET_DEF,
   parameter int SCORE_WIDTH = phv_pkg::SCORE_WIDTH_DEF
) (
   input  logic                                              clock,
   input  logic                                              ld_en,
   input  logic [phv_pkg::OP_W-1:0]                          ld_op,
   input  logic [phv_pkg::SYM_W-1:0]                         ld_row_sym,
   input  logic [phv_pkg::SYM_W-1:0]                         ld_col_sym,
   input  logic signed [SCORE_WIDTH-1:0]                     ld_value,
   input  logic [phv_pkg::POS_W-1:0]                         ld_pos,
   input  logic [phv_pkg::SYM_W-1:0]                         ld_seq_sym,
   input  phv_pkg::store_ctl_type                            ctl,
   input  logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0]  fs_addr,
   input  logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0]  ss_addr,
   output logic signed [SCORE_WIDTH-1:0]                     match_em,
   output logic signed [SCORE_WIDTH-1:0]                     row_gap_em,
   output logic signed [SCORE_WIDTH-1:0]                     col_gap_em
);
   import phv_pkg::*;

   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int GW = $clog2(ALPHABET);
   localparam int MW = $clog2(ALPHABET * ALPHABET);

   logic [SYM_W-1:0]              first_mem  [MAX_LEN];
   logic [SYM_W-1:0]              second_mem [MAX_LEN];
   logic signed [SCORE_WIDTH-1:0] gap_mem    [ALPHABET];
   logic signed [SCORE_WIDTH-1:0] match_mem  [ALPHABET * ALPHABET];

   logic [SYM_W-1:0]              fs_q_ff;
   logic [SYM_W-1:0]              fsym_ff;
   logic                          fsym_ok_ff;
   logic signed [SCORE_WIDTH-1:0] gap_row_q_ff;
   logic [SYM_W-1:0]              ss_q_ff;
   logic signed [SCORE_WIDTH-1:0] match_q_ff;
   logic signed [SCORE_WIDTH-1:0] gap_col_q_ff;
   logic                          col_ok_ff;
   logic                          pair_ok_ff;

   logic pos_ok;
   logic row_ok;
   logic col_ok;

   assign pos_ok = 32'(ld_pos) < MAX_LEN;
   assign row_ok = 32'(ld_row_sym) < ALPHABET;
   assign col_ok = 32'(ld_col_sym) < ALPHABET;

   // Store loads; drop out-of-range indexes
   always_ff @(posedge clock) begin
      if (ld_en) begin
         unique case (op_type'(ld_op))
            OP_LOAD_MATCH: begin
               if (row_ok && col_ok)
                  match_mem[MW'(32'(ld_row_sym) * ALPHABET + 32'(ld_col_sym))] <= ld_value;
            end
            OP_LOAD_GAP: begin
               if (row_ok) gap_mem[GW'(ld_row_sym)] <= ld_value;
            end
            OP_FIRST_SYM: begin
               if (pos_ok) first_mem[AW'(ld_pos)] <= ld_seq_sym;
            end
            OP_SECOND_SYM: begin
               if (pos_ok) second_mem[AW'(ld_pos)] <= ld_seq_sym;
            end
            default: ;
         endcase
      end
   end

   // Fetch the row symbol, then its gap emission
   always_ff @(posedge clock) begin
      if (ctl.fs_rd) fs_q_ff <= first_mem[fs_addr];
      if (ctl.row_gap_rd) begin
         fsym_ff      <= fs_q_ff;
         fsym_ok_ff   <= 32'(fs_q_ff) < ALPHABET;
         gap_row_q_ff <= gap_mem[GW'(fs_q_ff)];
      end
   end

   // Fetch the column symbol, then the match and column gap emissions
   always_ff @(posedge clock) begin
      if (ctl.ss_rd) ss_q_ff <= second_mem[ss_addr];
      if (ctl.em_rd) begin
         match_q_ff   <= match_mem[MW'(32'(fsym_ff) * ALPHABET + 32'(ss_q_ff))];
         gap_col_q_ff <= gap_mem[GW'(ss_q_ff)];
         col_ok_ff    <= 32'(ss_q_ff) < ALPHABET;
         pair_ok_ff   <= fsym_ok_ff && (32'(ss_q_ff) < ALPHABET);
      end
   end

   // Symbols outside the alphabet emit zero
   assign row_gap_em = fsym_ok_ff ? gap_row_q_ff : '0;
   assign col_gap_em = col_ok_ff ? gap_col_q_ff : '0;
   assign match_em   = pair_ok_ff ? match_q_ff : '0;

endmodule

### rtl/core/phv_cell.sv
module phv_cell #(
   parameter int MAX_LEN     = phv_pkg::MAX_LEN_DEF,
   parameter int SCORE_WIDTH = phv_pkg::SCORE_WIDTH_DEF
) (
   input  logic                               clock,
   input  phv_pkg::cell_ctl_type              ctl,
   input  logic [$clog2(MAX_LEN + 1)-1:0]     rd_addr,
   input  logic [$clog2(MAX_LEN + 1)-1:0]     wr_addr,
   input  logic signed [SCORE_WIDTH-1:0]      mm,
   input  logic signed [SCORE_WIDTH-1:0]      gm,
   input  logic signed [SCORE_WIDTH-1:0]      mg,
   input  logic signed [SCORE_WIDTH-1:0]      ge,
   input  logic signed [SCORE_WIDTH-1:0]      gs,
   input  logic signed [SCORE_WIDTH-1:0]      match_em,
   input  logic signed [SCORE_WIDTH-1:0]      row_gap_em,
   input  logic signed [SCORE_WIDTH-1:0]      col_gap_em,
   output logic signed [phv_pkg::OUT_W-1:0]   fin_match,
   output logic signed [phv_pkg::OUT_W-1:0]   fin_insert,
   output logic signed [phv_pkg::OUT_W-1:0]   fin_delete,
   output logic [phv_pkg::END_W-1:0]          best_state
);
   import phv_pkg::*;

   localparam int SW    = SCORE_WIDTH;
   localparam int ROW_W = 3 * SW;
   localparam logic signed [SW-1:0] NEG_INF = {1'b1, {(SW - 1){1'b0}}};

   function automatic logic signed [SW-1:0] add_s(input logic signed [SW-1:0] a,
                                                  input logic signed [SW-1:0] b);
      return SW'(phv_sadd(64'(a), 64'(b), SW));
   endfunction

   function automatic logic signed [SW-1:0] max3(input logic signed [SW-1:0] m,
                                                 input logic signed [SW-1:0] x,
                                                 input logic signed [SW-1:0] y);
      if (m >= x && m >= y) return m;
      if (x >= y) return x;
      return y;
   endfunction

   logic [ROW_W-1:0] row_mem [MAX_LEN + 1];
   logic [ROW_W-1:0] row_q_ff;

   logic signed [SW-1:0] cur_m_ff, cur_x_ff, cur_y_ff;
   logic signed [SW-1:0] diag_m_ff, diag_x_ff, diag_y_ff;
   logic signed [SW-1:0] old_m, old_x, old_y;
   logic signed [SW-1:0] new_m, new_x, new_y;

   // Previous row at this column; the first row has none
   always_comb begin
      if (ctl.first_row) begin
         old_m = NEG_INF;
         old_x = NEG_INF;
         old_y = NEG_INF;
      end else begin
         old_m = row_q_ff[3*SW-1:2*SW];
         old_x = row_q_ff[2*SW-1:SW];
         old_y = row_q_ff[SW-1:0];
      end
   end

   // Cell recurrence: insert from above, delete from the left, match from the diagonal
   always_comb begin
      new_x = ctl.first_row ? NEG_INF :
              add_s(max3(add_s(old_m, mg), add_s(old_x, ge), add_s(old_y, gs)), row_gap_em);
      new_y = ctl.first_col ? NEG_INF :
              add_s(max3(add_s(cur_m_ff, mg), add_s(cur_x_ff, gs), add_s(cur_y_ff, ge)),
                    col_gap_em);
      if (ctl.first_row || ctl.first_col)
         new_m = (ctl.first_row && ctl.first_col) ? '0 : NEG_INF;
      else
         new_m = add_s(max3(add_s(diag_m_ff, mm), add_s(diag_x_ff, gm), add_s(diag_y_ff, gm)),
                       match_em);
   end

   // Read the old row ahead, write the new cell back
   always_ff @(posedge clock) begin
      if (ctl.rd) row_q_ff <= row_mem[rd_addr];
      if (ctl.calc) begin
         row_mem[wr_addr] <= {new_m, new_x, new_y};
         cur_m_ff  <= new_m;
         cur_x_ff  <= new_x;
         cur_y_ff  <= new_y;
         diag_m_ff <= old_m;
         diag_x_ff <= old_x;
         diag_y_ff <= old_y;
      end
   end

   // Last cell written is the final cell of the run
   assign fin_match  = OUT_W'(phv_sat(65'(cur_m_ff), OUT_W));
   assign fin_insert = OUT_W'(phv_sat(65'(cur_x_ff), OUT_W));
   assign fin_delete = OUT_W'(phv_sat(65'(cur_y_ff), OUT_W));

   always_comb begin
      if (cur_m_ff >= cur_x_ff && cur_m_ff >= cur_y_ff) best_state = END_MATCH;
      else if (cur_x_ff >= cur_y_ff)                    best_state = END_INSERT;
      else                                              best_state = END_DELETE;
   end

endmodule

### rtl/core/pair_hmm_viterbi_score.sv
// Load items: one transfer per cycle while idle, written to the stores in the accept cycle.
// Run item: the matrix is swept one cell per cycle through the row memory; each row
// ends in the drain state, and each later row opens with the symbol and gap fetch
// states; no item is taken until the result is loaded into the result register.
// Reset (synchronous, active high) clears control and configuration registers;
// sequence and emission stores are not cleared and must be loaded before a run.
module pair_hmm_viterbi_score #(
   parameter int MAX_LEN     = phv_pkg::MAX_LEN_DEF,
   parameter int ALPHABET    = phv_pkg::ALPHABET_DEF,
   parameter int SCORE_WIDTH = phv_pkg::SCORE_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [phv_pkg::OP_W-1:0]            req_operation,
   input  logic [phv_pkg::SYM_W-1:0]           req_row_symbol,
   input  logic [phv_pkg::SYM_W-1:0]           req_col_symbol,
   input  logic signed [phv_pkg::VAL_W-1:0]    req_log_value,
   input  logic [phv_pkg::POS_W-1:0]           req_position,
   input  logic [phv_pkg::SYM_W-1:0]           req_seq_symbol,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [phv_pkg::OUT_W-1:0]    rsp_final_match_score,
   output logic signed [phv_pkg::OUT_W-1:0]    rsp_final_insert_score,
   output logic signed [phv_pkg::OUT_W-1:0]    rsp_final_delete_score,
   output logic [phv_pkg::END_W-1:0]           rsp_best_end_state,
   input  logic                                csr_we,
   input  logic [phv_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [phv_pkg::VAL_W-1:0]           csr_wdata
);
   import phv_pkg::*;

   localparam int SW = SCORE_WIDTH;
   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int RW = $clog2(MAX_LEN + 1);

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_ROW_SYM = 6'b000010,
      S_ROW_GAP = 6'b000100,
      S_ROW_RUN = 6'b001000,
      S_DRAIN   = 6'b010000,
      S_FINISH  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [RW-1:0] row_ff, row_in;
   logic [RW-1:0] col_ff, col_in;
   logic [RW-1:0] n1_ff, n1_in;
   logic [RW-1:0] n2_ff, n2_in;
   logic          s1_v_ff, s2_v_ff;
   logic [RW-1:0] s1_col_ff, s2_col_ff;

   logic signed [SW-1:0] mm_ff, gm_ff, mg_ff, ge_ff, gs_ff;
   logic [LEN_W-1:0]     len1_ff, len2_ff;
   logic signed [SW-1:0] csr_val;
   logic signed [SW-1:0] ld_value;

   logic                 rsp_valid_ff;
   logic signed [OUT_W-1:0] rsp_m_ff, rsp_x_ff, rsp_y_ff;
   logic [END_W-1:0]     rsp_best_ff;

   logic          req_xfer;
   logic          run_start;
   logic          issue;
   logic          rsp_load;

   store_ctl_type sctl;
   cell_ctl_type  cctl;
   logic signed [SW-1:0]    match_em, row_gap_em, col_gap_em;
   logic signed [OUT_W-1:0] fin_m, fin_x, fin_y;
   logic [END_W-1:0]        fin_best;

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign run_start = req_xfer && (op_type'(req_operation) == OP_RUN);
   assign issue     = (state_ff == S_ROW_RUN);
   assign rsp_load  = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);

   assign csr_val  = SW'(phv_sat(65'($signed(csr_wdata)), SW));
   assign ld_value = SW'(phv_sat(65'(req_log_value), SW));

   // Clamp lengths to the store depth
   assign n1_in = (32'(len1_ff) > MAX_LEN) ? RW'(MAX_LEN) : RW'(len1_ff);
   assign n2_in = (32'(len2_ff) > MAX_LEN) ? RW'(MAX_LEN) : RW'(len2_ff);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mm_ff   <= '0;
         gm_ff   <= '0;
         mg_ff   <= '0;
         ge_ff   <= '0;
         gs_ff   <= '0;
         len1_ff <= '0;
         len2_ff <= '0;
      end else if (csr_we) begin
         unique case (reg_type'(csr_index))
            REG_MATCH_TO_MATCH: mm_ff   <= csr_val;
            REG_GAP_TO_MATCH:   gm_ff   <= csr_val;
            REG_MATCH_TO_GAP:   mg_ff   <= csr_val;
            REG_GAP_EXTEND:     ge_ff   <= csr_val;
            REG_GAP_SWITCH:     gs_ff   <= csr_val;
            REG_FIRST_LEN:      len1_ff <= csr_wdata[LEN_W-1:0];
            REG_SECOND_LEN:     len2_ff <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer: rows, then columns within a row
   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (run_start) begin
               row_in   = '0;
               col_in   = '0;
               state_in = S_ROW_RUN;
            end
         end
         S_ROW_SYM: state_in = S_ROW_GAP;
         S_ROW_GAP: state_in = S_ROW_RUN;
         S_ROW_RUN: begin
            if (col_ff == n2_ff) state_in = S_DRAIN;
            else                 col_in   = col_ff + 1'b1;
         end
         S_DRAIN: begin
            if (!s1_v_ff && !s2_v_ff) begin
               if (row_ff == n1_ff) begin
                  state_in = S_FINISH;
               end else begin
                  row_in   = row_ff + 1'b1;
                  col_in   = '0;
                  state_in = S_ROW_SYM;
               end
            end
         end
         S_FINISH: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         s1_v_ff  <= issue;
         s2_v_ff  <= s1_v_ff;
      end
      row_ff    <= row_in;
      col_ff    <= col_in;
      s1_col_ff <= col_ff;
      s2_col_ff <= s1_col_ff;
      if (run_start) begin
         n1_ff <= n1_in;
         n2_ff <= n2_in;
      end
   end

   // Result register: hold until transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_m_ff    <= fin_m;
         rsp_x_ff    <= fin_x;
         rsp_y_ff    <= fin_y;
         rsp_best_ff <= fin_best;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_final_match_score  = rsp_m_ff;
   assign rsp_final_insert_score = rsp_x_ff;
   assign rsp_final_delete_score = rsp_y_ff;
   assign rsp_best_end_state     = rsp_best_ff;

   // Store reads: row symbol and row gap in the fetch states, column symbol at issue, emissions from the s1 stage
   always_comb begin
      sctl.fs_rd      = (state_ff == S_ROW_SYM);
      sctl.row_gap_rd = (state_ff == S_ROW_GAP);
      sctl.ss_rd      = issue && (col_ff != '0);
      sctl.em_rd      = s1_v_ff && (s1_col_ff != '0);
      cctl.rd         = s1_v_ff;
      cctl.calc       = s2_v_ff;
      cctl.first_row  = (row_ff == '0);
      cctl.first_col  = (s2_col_ff == '0);
   end

   phv_store #(
      .MAX_LEN     (MAX_LEN),
      .ALPHABET    (ALPHABET),
      .SCORE_WIDTH (SCORE_WIDTH)
   ) u_store (
      .clock      (clock),
      .ld_en      (req_xfer),
      .ld_op      (req_operation),
      .ld_row_sym (req_row_symbol),
      .ld_col_sym (req_col_symbol),
      .ld_value   (ld_value),
      .ld_pos     (req_position),
      .ld_seq_sym (req_seq_symbol),
      .ctl        (sctl),
      .fs_addr    (AW'(row_ff - 1'b1)),
      .ss_addr    (AW'(col_ff - 1'b1)),
      .match_em   (match_em),
      .row_gap_em (row_gap_em),
      .col_gap_em (col_gap_em)
   );

   phv_cell #(
      .MAX_LEN     (MAX_LEN),
      .SCORE_WIDTH (SCORE_WIDTH)
   ) u_cell (
      .clock      (clock),
      .ctl        (cctl),
      .rd_addr    (s1_col_ff),
      .wr_addr    (s2_col_ff),
      .mm         (mm_ff),
      .gm         (gm_ff),
      .mg         (mg_ff),
      .ge         (ge_ff),
      .gs         (gs_ff),
      .match_em   (match_em),
      .row_gap_em (row_gap_em),
      .col_gap_em (col_gap_em),
      .fin_match  (fin_m),
      .fin_insert (fin_x),
      .fin_delete (fin_y),
      .best_state (fin_best)
   );

`ifndef SYNTH
   a_calc_in_sweep: assert property (@(posedge clock) disable iff (reset)
      s2_v_ff |-> (state_ff == S_ROW_RUN || state_ff == S_DRAIN))
      else $error("cell update outside a row sweep");

   a_run_starts: assert property (@(posedge clock) disable iff (reset)
      run_start |=> state_ff == S_ROW_RUN && row_ff == '0 && col_ff == '0)
      else $error("run did not start at the first cell");

   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ROW_RUN |-> col_ff <= n2_ff && row_ff <= n1_ff)
      else $error("cell index beyond matrix");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("result raised outside finish");
`endif

endmodule

### verif/pair_hmm_viterbi_score_tb.sv
`timescale 1ns / 1ps

module pair_hmm_viterbi_score_tb;
   import phv_pkg::*;

   localparam int  TABLE_SYMS  = 32;
   localparam int  SEQ_DEPTH   = 1024;
   localparam int  SYM_USED    = 8;
   localparam int  PREFILL_LEN = 64;
   localparam int  CYCLE_LIMIT = 4000000;
   localparam int  PHASES      = 10;
   localparam int  PHASE_ITEMS = 40;
   localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_UNUSED_MID   = 3'd6;
   localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;
   localparam longint SCORE_MAX = 64'sd2147483647;
   localparam longint SCORE_MIN = -64'sd2147483648;

   typedef struct {
      logic [OP_W-1:0]         op;
      logic [SYM_W-1:0]        row_sym;
      logic [SYM_W-1:0]        col_sym;
      logic signed [VAL_W-1:0] value;
      logic [POS_W-1:0]        pos;
      logic [SYM_W-1:0]        sym;
   } load_item_type;

   typedef struct {
      logic signed [OUT_W-1:0] match_score;
      logic signed [OUT_W-1:0] insert_score;
      logic signed [OUT_W-1:0] delete_score;
      logic [END_W-1:0]        end_state;
   } final_scores_type;

   // Track the block's tables and registers and hold the expected final scores
   class viterbi_scoreboard;
      longint             trans[5];
      int unsigned        first_len, second_len;
      logic [4:0]         first_seq[SEQ_DEPTH];
      logic [4:0]         second_seq[SEQ_DEPTH];
      longint             match_em[TABLE_SYMS*TABLE_SYMS];
      longint             gap_em[TABLE_SYMS];
      longint             m_row[SEQ_DEPTH+1], i_row[SEQ_DEPTH+1], d_row[SEQ_DEPTH+1];
      final_scores_type   expected_scores[$];
      int                 errors;

      function new();
         foreach (trans[k]) trans[k] = 0;
         first_len = 0;
         second_len = 0;
         errors = 0;
      endfunction

      static function longint sat_add(longint a, longint b);
         longint s;
         if (a == SCORE_MIN || b == SCORE_MIN) return SCORE_MIN;
         s = a + b;
         if (s > SCORE_MAX) return SCORE_MAX;
         if (s < SCORE_MIN) return SCORE_MIN;
         return s;
      endfunction

      static function longint best_of(longint m, longint x, longint y);
         if (m >= x && m >= y) return m;
         if (x >= y) return x;
         return y;
      endfunction

      function void write_reg(reg_type idx, logic [31:0] data);
         int unsigned l;
         l = 32'(data[LEN_W-1:0]);
         if (l > SEQ_DEPTH) l = SEQ_DEPTH;
         case (idx)
            REG_FIRST_LEN:  first_len = l;
            REG_SECOND_LEN: second_len = l;
            default:        trans[idx] = longint'($signed(data));
         endcase
      endfunction

      // Sweep the matrix row by row, one row per state
      function final_scores_type score_run();
         final_scores_type r;
         longint dm, dx, dy, om, ox, oy, nm, nx, ny, fm, fx, fy;
         for (int i = 0; i <= first_len; i++) begin
            dm = SCORE_MIN; dx = SCORE_MIN; dy = SCORE_MIN;
            for (int j = 0; j <= second_len; j++) begin
               om = m_row[j]; ox = i_row[j]; oy = d_row[j];
               nm = SCORE_MIN; nx = SCORE_MIN; ny = SCORE_MIN;
               if (i == 0) begin
                  om = SCORE_MIN; ox = SCORE_MIN; oy = SCORE_MIN;
                  if (j == 0) nm = 0;
               end
               if (i != 0)
                  nx = sat_add(best_of(sat_add(om, trans[REG_MATCH_TO_GAP]),
                                       sat_add(ox, trans[REG_GAP_EXTEND]),
                                       sat_add(oy, trans[REG_GAP_SWITCH])),
                               gap_em[first_seq[i-1]]);
               if (j != 0)
                  ny = sat_add(best_of(sat_add(m_row[j-1], trans[REG_MATCH_TO_GAP]),
                                       sat_add(i_row[j-1], trans[REG_GAP_SWITCH]),
                                       sat_add(d_row[j-1], trans[REG_GAP_EXTEND])),
                               gap_em[second_seq[j-1]]);
               if (i != 0 && j != 0)
                  nm = sat_add(best_of(sat_add(dm, trans[REG_MATCH_TO_MATCH]),
                                       sat_add(dx, trans[REG_GAP_TO_MATCH]),
                                       sat_add(dy, trans[REG_GAP_TO_MATCH])),
                               match_em[first_seq[i-1]*TABLE_SYMS + second_seq[j-1]]);
               dm = om; dx = ox; dy = oy;
               m_row[j] = nm; i_row[j] = nx; d_row[j] = ny;
            end
         end
         fm = m_row[second_len]; fx = i_row[second_len]; fy = d_row[second_len];
         r.match_score  = fm[31:0];
         r.insert_score = fx[31:0];
         r.delete_score = fy[31:0];
         if (fm >= fx && fm >= fy) r.end_state = END_MATCH;
         else if (fx >= fy)        r.end_state = END_INSERT;
         else                      r.end_state = END_DELETE;
         return r;
      endfunction

      function void note_request(load_item_type it);
         case (it.op)
            OP_LOAD_MATCH: match_em[it.row_sym*TABLE_SYMS + it.col_sym] = it.value;
            OP_LOAD_GAP:   gap_em[it.row_sym] = it.value;
            OP_FIRST_SYM:  first_seq[it.pos] = it.sym;
            OP_SECOND_SYM: second_seq[it.pos] = it.sym;
            OP_RUN:        expected_scores.push_back(score_run());
            default: ;
         endcase
      endfunction

      function void check_result(final_scores_type got);
         final_scores_type want;
         if (expected_scores.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result transfer at %0t", $realtime);
            return;
         end
         want = expected_scores.pop_front();
         if (got.match_score !== want.match_score || got.insert_score !== want.insert_score ||
             got.delete_score !== want.delete_score || got.end_state !== want.end_state) begin
            errors++;
            if (errors <= 10)
               $display("mismatch at %0t: exp %0d %0d %0d %0d, got %0d %0d %0d %0d",
                        $realtime, want.match_score, want.insert_score, want.delete_score,
                        want.end_state, got.match_score, got.insert_score,
                        got.delete_score, got.end_state);
         end
      endfunction
   endclass

   logic                    clock, reset;
   logic                    req_valid, req_ready;
   logic [OP_W-1:0]         req_operation;
   logic [SYM_W-1:0]        req_row_symbol, req_col_symbol, req_seq_symbol;
   logic signed [VAL_W-1:0] req_log_value;
   logic [POS_W-1:0]        req_position;
   logic                    rsp_valid, rsp_ready;
   logic signed [OUT_W-1:0] rsp_final_match_score, rsp_final_insert_score;
   logic signed [OUT_W-1:0] rsp_final_delete_score;
   logic [END_W-1:0]        rsp_best_end_state;
   logic                    csr_we;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [VAL_W-1:0]        csr_wdata;

   viterbi_scoreboard scores = new();
   int  send_idle_pct, recv_idle_pct, recv_hold_cycles;
   int  cycle_count;

   pair_hmm_viterbi_score uut (.*);

   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Note every transfer on both channels
   always @(posedge clock) begin
      load_item_type    it;
      final_scores_type r;
      if (!reset && req_valid && req_ready) begin
         it.op = req_operation; it.row_sym = req_row_symbol; it.col_sym = req_col_symbol;
         it.value = req_log_value; it.pos = req_position; it.sym = req_seq_symbol;
         scores.note_request(it);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         r.match_score = rsp_final_match_score; r.insert_score = rsp_final_insert_score;
         r.delete_score = rsp_final_delete_score; r.end_state = rsp_best_end_state;
         scores.check_result(r);
      end
   end

   // Drive the result-side ready: random stalls, or a long hold-off when asked
   always @(negedge clock) begin
      if (recv_hold_cycles > 0) begin
         recv_hold_cycles--;
         rsp_ready = 1'b0;
      end else begin
         rsp_ready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_item(load_item_type it);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_valid = 1'b1;
      req_operation = it.op; req_row_symbol = it.row_sym; req_col_symbol = it.col_sym;
      req_log_value = it.value; req_position = it.pos; req_seq_symbol = it.sym;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_op(logic [OP_W-1:0] op, int rs, int cs, logic [31:0] v, int p, int s);
      load_item_type it;
      it.op = op; it.row_sym = SYM_W'(rs); it.col_sym = SYM_W'(cs); it.value = v;
      it.pos = POS_W'(p); it.sym = SYM_W'(s);
      send_item(it);
   endtask

   // Hold until every expected result has arrived and the block has settled
   task automatic wait_drained();
      while (scores.expected_scores.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(reg_type idx, logic [31:0] data);
      csr_we = 1'b1; csr_index = idx; csr_wdata = data;
      scores.write_reg(idx, data);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic configure(logic [31:0] mm, logic [31:0] gm, logic [31:0] mg,
                            logic [31:0] ge, logic [31:0] gs, logic [31:0] l1,
                            logic [31:0] l2);
      wait_drained();
      write_reg(REG_MATCH_TO_MATCH, mm);
      write_reg(REG_GAP_TO_MATCH, gm);
      write_reg(REG_MATCH_TO_GAP, mg);
      write_reg(REG_GAP_EXTEND, ge);
      write_reg(REG_GAP_SWITCH, gs);
      write_reg(REG_FIRST_LEN, l1);
      write_reg(REG_SECOND_LEN, l2);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(7))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'h0;
         3: return 32'hffffffff;
         4: return -$urandom_range(32'h00100000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_transition();
      case ($urandom_range(5))
         0: return 32'h80000000;
         1: return 32'h0;
         2: return 32'hffffffff;
         3: return 32'h80000000 | $urandom;
         default: return -$urandom_range(32'h00080000);
      endcase
   endfunction

   // Mostly short sequences, once in a while a longer one; random upper bits are ignored
   function automatic logic [31:0] pick_length();
      logic [31:0] up;
      up = $urandom & 32'hfffff800;
      if ($urandom_range(19) == 0) return up | $urandom_range(PREFILL_LEN);
      return up | $urandom_range(6);
   endfunction

   // Sequence symbols stay within the loaded part of the tables
   function automatic load_item_type random_item();
      load_item_type it;
      int            w;
      it.row_sym = SYM_W'($urandom); it.col_sym = SYM_W'($urandom); it.value = pick_value();
      it.pos = POS_W'($urandom); it.sym = SYM_W'($urandom_range(SYM_USED - 1));
      w = $urandom_range(99);
      if (w < 10)      it.op = OP_RUN;
      else if (w < 15) it.op = OP_W'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
      else if (w < 40) it.op = OP_LOAD_MATCH;
      else if (w < 55) it.op = OP_LOAD_GAP;
      else if (w < 78) it.op = OP_FIRST_SYM;
      else             it.op = OP_SECOND_SYM;
      // keep short runs interesting: mostly touch the front of the sequences
      if ($urandom_range(3) != 0) it.pos = POS_W'($urandom_range(7));
      return it;
   endfunction

   initial begin
      int l1, l2;
      reset = 1'b1; req_valid = 1'b0; req_operation = OP_LOAD_MATCH;
      req_row_symbol = '0; req_col_symbol = '0; req_log_value = '0;
      req_position = '0; req_seq_symbol = '0;
      csr_we = 1'b0; csr_index = REG_MATCH_TO_MATCH; csr_wdata = '0;
      rsp_ready = 1'b0; send_idle_pct = 0; recv_idle_pct = 0; recv_hold_cycles = 0;
      cycle_count = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Fill every table entry and sequence position that a run can reach
      for (int a = 0; a < SYM_USED; a++) begin
         send_op(OP_LOAD_GAP, a, 0, pick_value(), 0, 0);
         for (int b = 0; b < SYM_USED; b++)
            send_op(OP_LOAD_MATCH, a, b, pick_value(), 0, 0);
      end
      for (int p = 0; p < PREFILL_LEN; p++) begin
         send_op(OP_FIRST_SYM, 0, 0, 0, p, $urandom_range(SYM_USED - 1));
         send_op(OP_SECOND_SYM, 0, 0, 0, p, $urandom_range(SYM_USED - 1));
      end

      // Directed: empty sequences, one side empty, longest rows, extreme transitions
      send_op(OP_RUN, 0, 0, 0, 0, 0);
      configure(32'hffff0000, 32'hfffe0000, 32'hfffd0000, 32'hffff8000, 32'hfffc0000, 0, 3);
      send_op(OP_RUN, 0, 0, 0, 0, 0);
      configure(32'hffff0000, 32'hfffe0000, 32'hfffd0000, 32'hffff8000, 32'hfffc0000, 3, 0);
      send_op(OP_RUN, 0, 0, 0, 0, 0);
      configure(0, 0, 0, 0, 0, PREFILL_LEN, 1);
      send_op(OP_RUN, 0, 0, 0, 0, 0);
      configure(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1,
                PREFILL_LEN);
      send_op(OP_RUN, 0, 0, 0, 0, 0);
      configure(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 2, 2);
      send_op(OP_FIRST_SYM, 0, 0, 0, 0, SYM_USED - 1);
      send_op(OP_SECOND_SYM, 0, 0, 0, 0, 0);
      send_op(OP_LOAD_MATCH, SYM_USED - 1, 0, 32'h7fffffff, 0, 0);
      send_op(OP_LOAD_GAP, SYM_USED - 1, 0, 32'h80000000, 0, 0);
      send_op(OP_FIRST_SYM, 0, 0, 0, 1023, 5);
      send_op(OP_UNUSED_FIRST, 31, 31, 32'hffffffff, 1023, 31);
      send_op(OP_UNUSED_MID, 0, 0, 0, 0, 0);
      send_op(OP_UNUSED_LAST, 0, 0, 0, 0, 0);
      send_op(OP_RUN, 0, 0, 0, 0, 0);
      configure(0, 0, 32'h80000000, 0, 0, PREFILL_LEN, 3);
      send_op(OP_RUN, 0, 0, 0, 0, 0);

      // Random phases with fresh settings; idling pattern shifts across phases
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph < PHASES / 3) begin
            send_idle_pct = 12; recv_idle_pct = 70;
         end else if (ph < 2 * PHASES / 3) begin
            send_idle_pct = 70; recv_idle_pct = 12;
         end else begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end
         l1 = pick_length();
         l2 = pick_length();
         configure(pick_transition(), pick_transition(), pick_transition(),
                   pick_transition(), pick_transition(), l1, l2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 1 && n == 20) recv_hold_cycles = 400;
            if (ph == 5 && n == 30) wait_drained();
            send_item(random_item());
         end
      end

      // Drain
      for (int w = 0; w < 200000 && scores.expected_scores.size() != 0; w++)
         @(negedge clock);
      repeat (50) @(negedge clock);
      if (scores.expected_scores.size() != 0) scores.errors++;
      if (scores.errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
